### rtl/core/kmpbs_pkg.sv
`default_nettype none

package kmpbs_pkg;

    // Pattern storage is fixed at 16 bytes (two 64-bit registers)
    localparam int PAT_BYTES  = 16;
    localparam int PAT_IDX_W  = 4;
    localparam int PAT_W      = 8 * PAT_BYTES;
    localparam int FT_W       = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int PLEN_W     = 5;
    localparam int OUT_OFF_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Failure table write port
    typedef struct packed {
        logic                 en;
        logic [PAT_IDX_W-1:0] addr;
        logic [FT_W-1:0]      data;
    } t_ft_wr;

    function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat,
                                            input logic [PAT_IDX_W-1:0] k);
        return pat[{k, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

### rtl/core/kmpbs_ftab.sv
`default_nettype none

module kmpbs_ftab
    import kmpbs_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                 i_clk,
    input  wire t_ft_wr               i_wr,
    input  wire logic [PAT_IDX_W-1:0] i_rd_addr,
    output logic      [FT_W-1:0]      o_rd_data
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [FT_W-1:0] r_ft [MAX_PATTERN];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ft[i_wr.addr[IDX_W-1:0]] <= i_wr.data;
        end
    end

    // single read port, index chosen by the sequencer
    assign o_rd_data = r_ft[i_rd_addr[IDX_W-1:0]];

endmodule

`default_nettype wire

### rtl/core/kmp_byte_pattern_search.sv
// Flow: a byte is accepted in S_IDLE, then S_SEARCH compares it, falling back
//   through the failure table until it matches or the count is zero, and S_FINISH
//   loads the result register once the output is free. The first byte of a search
//   (or after a config write) first builds the table in S_BUILD for the active length.
// One byte in flight: a new byte is accepted only in S_IDLE, once the last result is
//   loaded; build and search share the single byte comparator.
// Reset: synchronous, active low; clears control, pattern bytes and search state,
//   pattern length returns to 1.
`default_nettype none

module kmp_byte_pattern_search
    import kmpbs_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_last_byte,
    // results
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_match_found,
    output logic      [OUT_OFF_W-1:0]  o_match_offset,
    output logic                       o_search_done
);

    // counters must hold the pattern length itself
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_BUILD  = 4'b0010,
        S_SEARCH = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [CFG_DATA_W-1:0] r_pat_lo, n_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi, n_pat_hi;
    logic [PLEN_W-1:0]     r_pat_len, n_pat_len;

    // search state
    logic                   r_table_ready, n_table_ready;
    logic [LEN_W-1:0]       r_matched, n_matched;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_found, n_found;
    logic [OFFSET_BITS-1:0] r_found_off, n_found_off;

    // current transaction and sequencer counters
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;
    logic [LEN_W-1:0] r_bi, n_bi;       // table build: position i
    logic [LEN_W-1:0] r_blen, n_blen;   // table build: prefix length
    logic [LEN_W-1:0] r_j, n_j;         // search: candidate match count

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_found, n_out_found;
    logic [OUT_OFF_W-1:0] r_out_off, n_out_off;
    logic                 r_out_done, n_out_done;

    logic [LEN_W-1:0]     act_len;
    logic [PAT_W-1:0]     pat;
    logic [PAT_IDX_W-1:0] cmp_idx;
    logic [7:0]           cmp_a, cmp_b;
    logic                 cmp_eq;
    t_ft_wr               ft_wr;
    logic [PAT_IDX_W-1:0] ft_rd_addr;
    logic [FT_W-1:0]      ft_rd_data;
    logic [LEN_W-1:0]     j_adv;

    assign pat = {r_pat_hi, r_pat_lo};

    // length register clamped to 1..MAX_PATTERN
    always_comb begin
        if (r_pat_len == '0) begin
            act_len = LEN_W'(1);
        end else if (r_pat_len > PLEN_W'(MAX_PATTERN)) begin
            act_len = LEN_W'(MAX_PATTERN);
        end else begin
            act_len = LEN_W'(r_pat_len);
        end
    end

    // Shared byte comparator: pattern[i] vs pattern[len] while building,
    // pattern[j] vs the stream byte while searching.
    assign cmp_idx    = (r_state == S_BUILD) ? PAT_IDX_W'(r_bi) : PAT_IDX_W'(r_j);
    assign cmp_a      = pat_byte(pat, cmp_idx);
    assign cmp_b      = (r_state == S_BUILD) ? pat_byte(pat, PAT_IDX_W'(r_blen)) : r_byte;
    assign cmp_eq     = (cmp_a == cmp_b);

    // table fallback read, only used when the count is nonzero
    assign ft_rd_addr = (r_state == S_BUILD) ? PAT_IDX_W'(r_blen - 1'b1)
                                             : PAT_IDX_W'(r_j - 1'b1);

    assign j_adv = r_j + LEN_W'(cmp_eq);

    kmpbs_ftab #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_ftab (
        .i_clk     (i_clk),
        .i_wr      (ft_wr),
        .i_rd_addr (ft_rd_addr),
        .o_rd_data (ft_rd_data)
    );

    always_comb begin
        n_state       = r_state;
        n_pat_lo      = r_pat_lo;
        n_pat_hi      = r_pat_hi;
        n_pat_len     = r_pat_len;
        n_table_ready = r_table_ready;
        n_matched     = r_matched;
        n_pos         = r_pos;
        n_found       = r_found;
        n_found_off   = r_found_off;
        n_byte        = r_byte;
        n_last        = r_last;
        n_bi          = r_bi;
        n_blen        = r_blen;
        n_j           = r_j;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_found   = r_out_found;
        n_out_off     = r_out_off;
        n_out_done    = r_out_done;
        ft_wr         = '0;

        // any write to a known register forces a table rebuild
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PATTERN_LOW: begin
                    n_pat_lo      = i_cfg_data;
                    n_table_ready = 1'b0;
                    n_matched     = '0;
                end
                REG_PATTERN_HIGH: begin
                    n_pat_hi      = i_cfg_data;
                    n_table_ready = 1'b0;
                    n_matched     = '0;
                end
                REG_PATTERN_LENGTH: begin
                    n_pat_len     = i_cfg_data[PLEN_W-1:0];
                    n_table_ready = 1'b0;
                    n_matched     = '0;
                end
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte = i_data_byte;
                    n_last = i_last_byte;
                    n_j    = (r_matched >= act_len) ? '0 : r_matched;
                    if (r_table_ready) begin
                        n_state = S_SEARCH;
                    end else begin
                        // failure[0] is always zero
                        ft_wr.en   = 1'b1;
                        ft_wr.addr = '0;
                        ft_wr.data = '0;
                        n_bi       = LEN_W'(1);
                        n_blen     = '0;
                        n_state    = S_BUILD;
                    end
                end
            end
            S_BUILD: begin
                if (r_bi >= act_len) begin
                    n_table_ready = 1'b1;
                    n_state       = S_SEARCH;
                end else if (cmp_eq) begin
                    ft_wr.en   = 1'b1;
                    ft_wr.addr = PAT_IDX_W'(r_bi);
                    ft_wr.data = FT_W'(r_blen + 1'b1);
                    n_blen     = r_blen + 1'b1;
                    n_bi       = r_bi + 1'b1;
                end else if (r_blen != '0) begin
                    n_blen = LEN_W'(ft_rd_data);
                end else begin
                    ft_wr.en   = 1'b1;
                    ft_wr.addr = PAT_IDX_W'(r_bi);
                    ft_wr.data = '0;
                    n_bi       = r_bi + 1'b1;
                end
            end
            S_SEARCH: begin
                if (r_found) begin
                    n_state = S_FINISH;
                end else if (r_j != '0 && !cmp_eq) begin
                    n_j = LEN_W'(ft_rd_data);
                end else begin
                    if (j_adv >= act_len) begin
                        n_found     = 1'b1;
                        n_found_off = r_pos - (OFFSET_BITS'(act_len) - 1'b1);
                        n_matched   = '0;
                    end else begin
                        n_matched   = j_adv;
                    end
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_off   = r_found ? OUT_OFF_W'(r_found_off) : '0;
                    n_out_done  = r_last;
                    if (r_pos != '1) begin
                        n_pos = r_pos + 1'b1;
                    end
                    if (r_last) begin
                        n_matched     = '0;
                        n_pos         = '0;
                        n_found       = 1'b0;
                        n_found_off   = '0;
                        n_table_ready = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pat_lo      <= '0;
            r_pat_hi      <= '0;
            r_pat_len     <= PLEN_W'(1);
            r_table_ready <= 1'b0;
            r_matched     <= '0;
            r_pos         <= '0;
            r_found       <= 1'b0;
            r_found_off   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pat_lo      <= n_pat_lo;
            r_pat_hi      <= n_pat_hi;
            r_pat_len     <= n_pat_len;
            r_table_ready <= n_table_ready;
            r_matched     <= n_matched;
            r_pos         <= n_pos;
            r_found       <= n_found;
            r_found_off   <= n_found_off;
            r_out_valid   <= n_out_valid;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_last      <= n_last;
        r_bi        <= n_bi;
        r_blen      <= n_blen;
        r_j         <= n_j;
        r_out_found <= n_out_found;
        r_out_off   <= n_out_off;
        r_out_done  <= n_out_done;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_match_found  = r_out_found;
    assign o_match_offset = r_out_off;
    assign o_search_done  = r_out_done;

endmodule

`default_nettype wire

### rtl/core/kmpbs_checker.sv
`default_nettype none

module kmpbs_checker
    import kmpbs_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic [7:0]            i_data_byte,
    input wire logic                  i_last_byte,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic                  o_match_found,
    input wire logic [OUT_OFF_W-1:0]  o_match_offset,
    input wire logic                  o_search_done
);

    // a result waiting for the sink must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_match_found) && $stable(o_match_offset)
             && $stable(o_search_done)))
        else $error("result changed while stalled");

    // offset reads zero until a match is found
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_match_found) |-> (o_match_offset == '0))
        else $error("nonzero offset without match");

    // one byte in flight: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second byte accepted while busy");

    // a waiting input byte keeps valid and payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_data_byte) && $stable(i_last_byte)))
        else $error("input changed while waiting");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind kmp_byte_pattern_search kmpbs_checker u_kmpbs_checker (.*);

`default_nettype wire

### sim/kmp_byte_pattern_search_checker.sv
module kmp_byte_pattern_search_checker
    import kmpbs_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_match_found,
    input  logic [OUT_OFF_W-1:0]  i_match_offset,
    input  logic                  i_search_done,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                 found;
        logic [OUT_OFF_W-1:0] offset;
        logic                 done;
    } t_search_result;

    t_search_result pending_results[$];

    // shadow of the pattern registers
    logic [PAT_W-1:0]       pattern;
    logic [PLEN_W-1:0]      length_reg;

    // search state
    logic [FT_W-1:0]        fallback [PAT_BYTES];
    logic                   table_built;
    int                     matched;
    logic [OFFSET_BITS-1:0] position;
    logic                   found;
    logic [OFFSET_BITS-1:0] first_offset;

    int fails = 0;

    // length code 0 behaves as 1, anything past the storage as full length
    function automatic int active_len();
        int n;
        n = int'(length_reg);
        if (n < 1) n = 1;
        if (n > PAT_BYTES) n = PAT_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] pat_at(int k);
        return pattern[8 * (k % PAT_BYTES) +: 8];
    endfunction

    function automatic void build_fallback();
        int n;
        int run;
        int i;
        n = active_len();
        run = 0;
        i = 1;
        fallback[0] = '0;
        while (i < n) begin
            if (pat_at(i) == pat_at(run)) begin
                run++;
                fallback[i] = FT_W'(run);
                i++;
            end else if (run != 0) begin
                run = int'(fallback[run - 1]);
            end else begin
                fallback[i] = '0;
                i++;
            end
        end
        table_built = 1'b1;
    endfunction

    function automatic void clear_search();
        matched      = 0;
        position     = '0;
        found        = 1'b0;
        first_offset = '0;
        table_built  = 1'b0;
    endfunction

    function automatic t_search_result scan_byte(logic [7:0] b, logic last);
        t_search_result r;
        int n;
        int j;
        if (!table_built) build_fallback();
        n = active_len();
        if (!found) begin
            j = matched;
            if (j >= n) j = 0;
            while (j > 0 && pat_at(j) != b) j = int'(fallback[j - 1]);
            if (pat_at(j) == b) j++;
            if (j >= n) begin
                found        = 1'b1;
                first_offset = position - OFFSET_BITS'(n - 1);
                j            = 0;
            end
            matched = j;
        end
        // position saturates rather than wrapping
        if (position != '1) position++;
        r.found  = found;
        r.offset = found ? OUT_OFF_W'(first_offset) : '0;
        r.done   = last;
        if (last) clear_search();
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_search_result want;
        if (!i_rst_n) begin
            pattern    = '0;
            length_reg = PLEN_W'(1);
            for (int k = 0; k < PAT_BYTES; k++) fallback[k] = '0;
            clear_search();
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no input awaiting it: found=%0d offset=%0d done=%0d",
                           i_match_found, i_match_offset, i_search_done);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_match_found !== want.found) begin
                        $error("match_found: expected %0d, got %0d", want.found, i_match_found);
                        fails++;
                    end
                    if (i_match_offset !== want.offset) begin
                        $error("match_offset: expected %0d, got %0d", want.offset,
                               i_match_offset);
                        fails++;
                    end
                    if (i_search_done !== want.done) begin
                        $error("search_done: expected %0d, got %0d", want.done, i_search_done);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PATTERN_LOW: begin
                        pattern[63:0] = i_cfg_data;
                        table_built   = 1'b0;
                        matched       = 0;
                    end
                    REG_PATTERN_HIGH: begin
                        pattern[127:64] = i_cfg_data;
                        table_built     = 1'b0;
                        matched         = 0;
                    end
                    REG_PATTERN_LENGTH: begin
                        length_reg  = i_cfg_data[PLEN_W-1:0];
                        table_built = 1'b0;
                        matched     = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(scan_byte(i_data_byte, i_last_byte));
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fails;
    end

endmodule

### sim/kmp_byte_pattern_search_tb.sv
module kmp_byte_pattern_search_tb;
    import kmpbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // stop once this many input transactions have gone through (directed part included)
    localparam int TOTAL_ITEMS    = 1520;
    // window of transactions during which neither side idles
    localparam int CALM_FROM      = 600;
    localparam int CALM_TO        = 800;
    // quiet cycles after the last result: table build plus worst search latency
    localparam int IDLE_CYCLES    = 40;
    // cycles without any transaction before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    // index 3 decodes to no register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte  = '0;
    logic                  last_byte  = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic                  match_found;
    logic [OUT_OFF_W-1:0]  match_offset;
    logic                  search_done;

    int   fail_count;
    int   pending;
    int   items_sent   = 0;
    int   stall_cycles = 0;
    logic calm         = 1'b0;

    // pattern as last loaded, kept so the stream can embed it
    logic [7:0] pat_bytes [PAT_BYTES];
    logic [7:0] alphabet  [3];
    int         act_len = 1;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    kmp_byte_pattern_search uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_last_byte    (last_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_match_found  (match_found),
        .o_match_offset (match_offset),
        .o_search_done  (search_done)
    );

    kmp_byte_pattern_search_checker result_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_last_byte    (last_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_match_found  (match_found),
        .i_match_offset (match_offset),
        .i_search_done  (search_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Result side back-pressure: about a third of cycles stalled, none in the calm window.
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 33);

    // Watchdog: any accepted transaction on either channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One byte transaction. Called right after a rising edge; returns at the edge that
    // accepted it with valid still high, so a following byte can go out back to back.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 33) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        calm <= (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
    endtask

    // Drop valid, wait until every result is back, then let the block go quiet.
    // The first edge lets the checker count a transaction accepted on this step.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        in_valid <= 1'b0;
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all three registers from pat_bytes. Upper bits of the length word are
    // random junk, the block must look only at the low field.
    task automatic load_pattern(input logic [PLEN_W-1:0] len_code);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] len_word;
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = pat_bytes[k];
            hi[8*k +: 8] = pat_bytes[k + 8];
        end
        len_word = {$urandom, $urandom};
        len_word[PLEN_W-1:0] = len_code;
        cfg_write(REG_PATTERN_LOW, lo);
        cfg_write(REG_PATTERN_HIGH, hi);
        cfg_write(REG_PATTERN_LENGTH, len_word);
        if (len_code == 0)
            act_len = 1;
        else if (len_code > PAT_BYTES)
            act_len = PAT_BYTES;
        else
            act_len = int'(len_code);
    endtask

    initial begin : stimulus
        logic [7:0]        stream[$];
        logic [PLEN_W-1:0] code;
        logic              wild;
        logic              ends;
        logic              reload;
        int                pick;
        int                n_bytes;
        int                run;

        for (int k = 0; k < PAT_BYTES; k++) pat_bytes[k] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---

        // reset pattern is one zero byte: miss, hit at offset 1, then done
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // length code 0 acts as length 1; hit on the very first byte
        settle();
        pat_bytes[0] = 8'hFF;
        load_pattern(5'd0);
        send_byte(8'hFF, 1'b1);

        // "aab" in "aaaba": third 'a' falls back through the table, hit at 1
        settle();
        pat_bytes[0] = 8'h61;
        pat_bytes[1] = 8'h61;
        pat_bytes[2] = 8'h62;
        load_pattern(5'd3);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b1);

        // write to the unused index mid-search: partial match of "ab" survives
        settle();
        pat_bytes[0] = 8'h61;
        pat_bytes[1] = 8'h62;
        load_pattern(5'd2);
        send_byte(8'h61, 1'b0);
        settle();
        cfg_write(REG_UNUSED, '1);
        send_byte(8'h62, 1'b0);
        send_byte(8'h78, 1'b1);

        // real register write mid-search: partial match dropped, position kept
        send_byte(8'h61, 1'b0);
        settle();
        cfg_write(REG_PATTERN_LENGTH, CFG_DATA_W'(2));
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);

        // length above storage clamps to 16; all-ones pattern, no match possible
        settle();
        for (int k = 0; k < PAT_BYTES; k++) pat_bytes[k] = 8'hFF;
        load_pattern(5'd31);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // --- random part ---
        // Patterns drawn mostly from a 3-symbol alphabet so that the stream,
        // built from pattern prefixes and alphabet bytes, drives deep fallbacks.
        reload = 1'b1;
        while (items_sent < TOTAL_ITEMS) begin
            if (reload || $urandom_range(99) < 35) begin
                settle();
                reload = 1'b0;
                wild = ($urandom_range(99) < 20);
                for (int k = 0; k < 3; k++) alphabet[k] = 8'($urandom);
                for (int k = 0; k < PAT_BYTES; k++)
                    pat_bytes[k] = wild ? 8'($urandom) : alphabet[$urandom_range(2)];
                pick = $urandom_range(99);
                if (pick < 50)
                    code = PLEN_W'($urandom_range(5, 1));
                else if (pick < 70)
                    code = PLEN_W'($urandom_range(15, 6));
                else if (pick < 80)
                    code = PLEN_W'(PAT_BYTES);
                else if (pick < 87)
                    code = '0;
                else
                    code = PLEN_W'($urandom_range(31, 17));
                load_pattern(code);
                if ($urandom_range(9) == 0)
                    cfg_write(REG_UNUSED, {$urandom, $urandom});
            end

            n_bytes = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
            stream.delete();
            while (stream.size() < n_bytes) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    run = ($urandom_range(1) == 1) ? act_len : $urandom_range(act_len, 1);
                    for (int k = 0; k < run; k++) stream.push_back(pat_bytes[k]);
                end else if (pick < 85) begin
                    stream.push_back(alphabet[$urandom_range(2)]);
                end else begin
                    stream.push_back(8'($urandom));
                end
            end

            // some searches run on into the next stream, possibly across a reload
            ends = ($urandom_range(99) < 85);
            foreach (stream[k])
                send_byte(stream[k], ends && (k == stream.size() - 1));
        end

        settle();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/core/kmpbs_pkg.sv
rtl/core/kmpbs_ftab.sv
rtl/core/kmp_byte_pattern_search.sv
rtl/core/kmpbs_checker.sv
sim/kmp_byte_pattern_search_checker.sv
sim/kmp_byte_pattern_search_tb.sv
